// File: hdl/monitor_lock_arbiter_defines.svh
// Assertion macros used by the monitor lock arbiter controller (mla_ctrl).
`ifndef MONITOR_LOCK_ARBITER_DEFINES_SVH
`define MONITOR_LOCK_ARBITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MLA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MLA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/mla_pkg.sv
`default_nettype none

package mla_pkg;

   // Parameter defaults
   localparam int MAX_CONDITIONS_DFLT = 8;
   localparam int QUEUE_DEPTH_DFLT    = 16;
   localparam int ID_BITS_DFLT        = 8;

   // Field widths
   localparam int ACTION_W    = 2;
   localparam int REQUESTER_W = 8;
   localparam int CONDITION_W = 3;
   localparam int GRANT_W     = 8;
   localparam int STATUS_W    = 2;
   localparam int NCOND_W     = 4;
   localparam int ID_WIDE_W   = 16;

   localparam logic [NCOND_W-1:0] NCOND_RESET = 4'd8;

   // Request kinds
   localparam logic [ACTION_W-1:0] ACT_ENTER  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LEAVE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_WAIT   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_SIGNAL = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_GRANT  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOCOND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

   // Queue numbering: entry, urgent, then one per condition
   localparam int Q_ENTRY     = 0;
   localparam int Q_URGENT    = 1;
   localparam int Q_COND_BASE = 2;

   typedef struct packed {
      logic load;     // latch an accepted request
      logic exec;     // run the queue update for the held request
      logic second;   // present the second result of the request
   } mla_cmd_type;

   typedef struct packed {
      logic [1:0] exec_cnt;   // results the held request produces (execute cycle)
      logic [1:0] res_cnt;    // registered result count of the current request
   } mla_stat_type;

endpackage

`default_nettype wire

// File: hdl/mla_ifs.sv
`default_nettype none

interface mla_req_if;
   import mla_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [ACTION_W-1:0]    action;
   logic [REQUESTER_W-1:0] requester;
   logic [CONDITION_W-1:0] condition;

   modport source (output valid, action, requester, condition, input ready);
   modport sink   (input valid, action, requester, condition, output ready);
endinterface

interface mla_rsp_if;
   import mla_pkg::*;
   logic                valid;
   logic                ready;
   logic [GRANT_W-1:0]  grant_thread;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, grant_thread, status, last, input ready);
   modport sink   (input valid, grant_thread, status, last, output ready);
endinterface

`default_nettype wire

// File: hdl/monitor_lock_arbiter.sv
// Channel   Dir  Handshake    Payload
// req_if    in   valid/ready  action, requester, condition
// rsp_if    out  valid/ready  grant_thread, status, last
// csr_*     in   write enable num_conditions (csr_wdata)
//
// A request is executed in the cycle after it is taken: that cycle makes
// the single queue-memory write and the single registered queue-memory read.
// A request gives no, one or two results; with none it returns to idle once
// executed, else the next request may be taken on the same edge as its last result.
// A stall on rsp_if holds the result; no new request is taken meanwhile.
// Reset (synchronous) empties all queues, frees the monitor and sets
// num_conditions to 8; queue memory is not cleared and needs no sweep.
`default_nettype none

module monitor_lock_arbiter #(
   parameter int MAX_CONDITIONS = mla_pkg::MAX_CONDITIONS_DFLT,
   parameter int QUEUE_DEPTH    = mla_pkg::QUEUE_DEPTH_DFLT,
   parameter int ID_BITS        = mla_pkg::ID_BITS_DFLT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [mla_pkg::NCOND_W-1:0] csr_wdata,
   mla_req_if.sink                     req_if,
   mla_rsp_if.source                   rsp_if
);
   import mla_pkg::*;

   mla_cmd_type  cmd;
   mla_stat_type stat;

   // Sequencer: take a request, execute it, then deliver its results
   mla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Occupied flag, queue counts and heads, queue memory and result fields
   mla_datapath #(
      .MAX_CONDITIONS (MAX_CONDITIONS),
      .QUEUE_DEPTH    (QUEUE_DEPTH),
      .ID_BITS        (ID_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_action       (req_if.action),
      .req_requester    (req_if.requester),
      .req_condition    (req_if.condition),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_grant_thread (rsp_if.grant_thread),
      .rsp_status       (rsp_if.status),
      .rsp_last         (rsp_if.last)
   );

endmodule

`default_nettype wire

// File: hdl/mla_datapath.sv
`default_nettype none

module mla_datapath #(
   parameter int MAX_CONDITIONS = mla_pkg::MAX_CONDITIONS_DFLT,
   parameter int QUEUE_DEPTH    = mla_pkg::QUEUE_DEPTH_DFLT,
   parameter int ID_BITS        = mla_pkg::ID_BITS_DFLT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [mla_pkg::NCOND_W-1:0]     csr_wdata,
   input  logic [mla_pkg::ACTION_W-1:0]    req_action,
   input  logic [mla_pkg::REQUESTER_W-1:0] req_requester,
   input  logic [mla_pkg::CONDITION_W-1:0] req_condition,
   input  mla_pkg::mla_cmd_type            cmd,
   output mla_pkg::mla_stat_type           stat,
   output logic [mla_pkg::GRANT_W-1:0]     rsp_grant_thread,
   output logic [mla_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_last
);
   import mla_pkg::*;

   localparam int NumQueues = Q_COND_BASE + MAX_CONDITIONS;
   localparam int QIdxW     = $clog2(NumQueues);
   localparam int PosW      = $clog2(QUEUE_DEPTH);
   localparam int CntW      = $clog2(QUEUE_DEPTH + 1);
   localparam int SumW      = CntW + 1;
   localparam int AddrW     = QIdxW + PosW;
   localparam int MemDepth  = NumQueues << PosW;
   localparam int NcEffW    = 5;

   localparam logic [1:0] SEL_ENTRY  = 2'd0;
   localparam logic [1:0] SEL_URGENT = 2'd1;
   localparam logic [1:0] SEL_COND   = 2'd2;

   // Control state
   logic [NCOND_W-1:0] ncond_ff, ncond_in;
   logic               occupied_ff, occupied_in;
   logic [1:0]         res_cnt_ff, res_cnt_in;
   logic [CntW-1:0]    cnt_ff [NumQueues];
   logic [CntW-1:0]    cnt_in [NumQueues];
   logic [PosW-1:0]    head_ff [NumQueues];
   logic [PosW-1:0]    head_in [NumQueues];

   // Payload
   logic [ACTION_W-1:0]    act_ff, act_in;
   logic [ID_BITS-1:0]     id_ff, id_in;
   logic [CONDITION_W-1:0] cond_ff, cond_in;
   logic                   first_pop_ff, first_pop_in;
   logic [STATUS_W-1:0]    first_status_ff, first_status_in;
   logic [ID_BITS-1:0]     rd_data_ff;
   logic [ID_BITS-1:0]     queue_mem [MemDepth];

   logic [ID_WIDE_W-1:0] req_wide;
   logic [ID_WIDE_W-1:0] out_wide;
   logic [ID_BITS-1:0]   out_id;

   logic [NcEffW-1:0] ncond_eff;
   logic              cond_ok;
   logic [QIdxW-1:0]  cq;
   logic [CntW-1:0]   cq_cnt, ent_cnt, urg_cnt;
   logic [PosW-1:0]   cq_head, ent_head, urg_head;
   logic              ho_pop;
   logic [1:0]        ho_sel;

   logic             do_push, do_pop, occ_set, occ_clr, dec_first_pop;
   logic [1:0]       push_sel, pop_sel, dec_cnt;
   logic [STATUS_W-1:0] dec_status;
   logic [QIdxW-1:0] push_q, pop_q;
   logic [CntW-1:0]  push_cnt;
   logic [PosW-1:0]  push_head, pop_head, pop_head_next, tail_pos;
   logic [SumW-1:0]  tail_sum;
   logic [AddrW-1:0] waddr, raddr;

   assign req_wide = ID_WIDE_W'(req_requester);
   assign id_in    = cmd.load ? req_wide[ID_BITS-1:0] : id_ff;
   assign act_in   = cmd.load ? req_action : act_ff;
   assign cond_in  = cmd.load ? req_condition : cond_ff;
   assign ncond_in = csr_we ? csr_wdata : ncond_ff;

   // Clamp the condition count to what is built
   assign ncond_eff = (NcEffW'(ncond_ff) > NcEffW'(MAX_CONDITIONS)) ?
                      NcEffW'(MAX_CONDITIONS) : NcEffW'(ncond_ff);
   assign cond_ok   = NcEffW'(cond_ff) < ncond_eff;
   assign cq        = QIdxW'(int'(cond_ff) + Q_COND_BASE);

   assign cq_cnt   = cnt_ff[cq];
   assign cq_head  = head_ff[cq];
   assign ent_cnt  = cnt_ff[Q_ENTRY];
   assign ent_head = head_ff[Q_ENTRY];
   assign urg_cnt  = cnt_ff[Q_URGENT];
   assign urg_head = head_ff[Q_URGENT];

   // Hand the monitor on: urgent first, then entry
   assign ho_pop = (urg_cnt != '0) || (ent_cnt != '0);
   assign ho_sel = (urg_cnt != '0) ? SEL_URGENT : SEL_ENTRY;

   always_comb begin
      do_push       = 1'b0;
      do_pop        = 1'b0;
      push_sel      = SEL_ENTRY;
      pop_sel       = SEL_ENTRY;
      occ_set       = 1'b0;
      occ_clr       = 1'b0;
      dec_cnt       = 2'd0;
      dec_first_pop = 1'b0;
      dec_status    = ST_GRANT;
      unique case (act_ff)
         ACT_ENTER: begin
            if (!occupied_ff) begin
               occ_set = 1'b1;
               dec_cnt = 2'd1;
            end else if (ent_cnt == CntW'(QUEUE_DEPTH)) begin
               dec_cnt    = 2'd1;
               dec_status = ST_FULL;
            end else begin
               do_push  = 1'b1;
               push_sel = SEL_ENTRY;
            end
         end
         ACT_LEAVE: begin
            dec_cnt = 2'd1;
            if (ho_pop) begin
               do_pop  = 1'b1;
               pop_sel = ho_sel;
               dec_cnt = 2'd2;
            end else begin
               occ_clr = 1'b1;
            end
         end
         ACT_WAIT: begin
            if (!cond_ok) begin
               dec_cnt    = 2'd1;
               dec_status = ST_NOCOND;
            end else if (cq_cnt == CntW'(QUEUE_DEPTH)) begin
               dec_cnt    = 2'd1;
               dec_status = ST_FULL;
            end else begin
               do_push  = 1'b1;
               push_sel = SEL_COND;
               if (ho_pop) begin
                  do_pop        = 1'b1;
                  pop_sel       = ho_sel;
                  dec_cnt       = 2'd1;
                  dec_first_pop = 1'b1;
               end else begin
                  occ_clr = 1'b1;
               end
            end
         end
         default: begin
            dec_cnt = 2'd1;
            if (!cond_ok) begin
               dec_status = ST_NOCOND;
            end else if (cq_cnt == '0) begin
               dec_status = ST_GRANT;
            end else if (urg_cnt == CntW'(QUEUE_DEPTH)) begin
               dec_status = ST_FULL;
            end else begin
               do_pop        = 1'b1;
               pop_sel       = SEL_COND;
               do_push       = 1'b1;
               push_sel      = SEL_URGENT;
               dec_first_pop = 1'b1;
            end
         end
      endcase
   end

   // Queue selection for the push and the pop
   always_comb begin
      unique case (push_sel)
         SEL_URGENT: begin
            push_q    = QIdxW'(Q_URGENT);
            push_cnt  = urg_cnt;
            push_head = urg_head;
         end
         SEL_COND: begin
            push_q    = cq;
            push_cnt  = cq_cnt;
            push_head = cq_head;
         end
         default: begin
            push_q    = QIdxW'(Q_ENTRY);
            push_cnt  = ent_cnt;
            push_head = ent_head;
         end
      endcase
      unique case (pop_sel)
         SEL_URGENT: begin
            pop_q    = QIdxW'(Q_URGENT);
            pop_head = urg_head;
         end
         SEL_COND: begin
            pop_q    = cq;
            pop_head = cq_head;
         end
         default: begin
            pop_q    = QIdxW'(Q_ENTRY);
            pop_head = ent_head;
         end
      endcase
   end

   // Tail = head + count, wrapped once
   always_comb begin
      tail_sum = SumW'(push_head) + SumW'(push_cnt);
      if (tail_sum >= SumW'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - SumW'(QUEUE_DEPTH);
      end
      tail_pos = tail_sum[PosW-1:0];
   end

   assign pop_head_next = (pop_head == PosW'(QUEUE_DEPTH - 1)) ? '0 : pop_head + 1'b1;
   assign waddr         = {push_q, tail_pos};
   assign raddr         = {pop_q, pop_head};

   always_comb begin
      for (int q = 0; q < NumQueues; q++) begin
         cnt_in[q]  = cnt_ff[q];
         head_in[q] = head_ff[q];
         if (cmd.exec && do_push && (push_q == QIdxW'(q))) begin
            cnt_in[q] = cnt_ff[q] + 1'b1;
         end
         if (cmd.exec && do_pop && (pop_q == QIdxW'(q))) begin
            cnt_in[q]  = cnt_ff[q] - 1'b1;
            head_in[q] = pop_head_next;
         end
      end
   end

   always_comb begin
      occupied_in = occupied_ff;
      if (cmd.exec && occ_set) begin
         occupied_in = 1'b1;
      end else if (cmd.exec && occ_clr) begin
         occupied_in = 1'b0;
      end
   end

   assign res_cnt_in      = cmd.exec ? dec_cnt : res_cnt_ff;
   assign first_pop_in    = cmd.exec ? dec_first_pop : first_pop_ff;
   assign first_status_in = cmd.exec ? dec_status : first_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ncond_ff    <= NCOND_RESET;
         occupied_ff <= 1'b0;
         res_cnt_ff  <= 2'd0;
         for (int q = 0; q < NumQueues; q++) begin
            cnt_ff[q]  <= '0;
            head_ff[q] <= '0;
         end
      end else begin
         ncond_ff    <= ncond_in;
         occupied_ff <= occupied_in;
         res_cnt_ff  <= res_cnt_in;
         for (int q = 0; q < NumQueues; q++) begin
            cnt_ff[q]  <= cnt_in[q];
            head_ff[q] <= head_in[q];
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff          <= act_in;
      id_ff           <= id_in;
      cond_ff         <= cond_in;
      first_pop_ff    <= first_pop_in;
      first_status_ff <= first_status_in;
   end

   // Queue storage: one write and one registered read per execute cycle
   always_ff @(posedge clock) begin
      if (cmd.exec && do_push) begin
         queue_mem[waddr] <= id_ff;
      end
      if (cmd.exec && do_pop) begin
         rd_data_ff <= queue_mem[raddr];
      end
   end

   assign stat.exec_cnt = dec_cnt;
   assign stat.res_cnt  = res_cnt_ff;

   assign out_id           = (cmd.second || first_pop_ff) ? rd_data_ff : id_ff;
   assign out_wide         = ID_WIDE_W'(out_id);
   assign rsp_grant_thread = out_wide[GRANT_W-1:0];
   assign rsp_status       = cmd.second ? ST_GRANT : first_status_ff;
   assign rsp_last         = cmd.second || (res_cnt_ff == 2'd1);

endmodule

`default_nettype wire

// File: hdl/mla_ctrl.sv
`default_nettype none

`include "monitor_lock_arbiter_defines.svh"

module mla_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mla_pkg::mla_cmd_type  cmd,
   input  mla_pkg::mla_stat_type stat
);
   import mla_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_RSP0 = 2'd2;
   localparam logic [1:0] S_RSP1 = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       final_beat;
   logic       load;

   // Last result of a request taken: a new request may enter on the same edge
   assign final_beat = rsp_ready &&
                       (((state_ff == S_RSP0) && (stat.res_cnt == 2'd1)) ||
                        (state_ff == S_RSP1));
   assign req_ready  = (state_ff == S_IDLE) || final_beat;
   assign load       = req_valid && req_ready;
   assign rsp_valid  = (state_ff == S_RSP0) || (state_ff == S_RSP1);

   assign cmd.load   = load;
   assign cmd.exec   = (state_ff == S_EXEC);
   assign cmd.second = (state_ff == S_RSP1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (load) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = (stat.exec_cnt == 2'd0) ? S_IDLE : S_RSP0;
         end
         S_RSP0: begin
            if (rsp_ready) begin
               if (stat.res_cnt == 2'd2) begin
                  state_in = S_RSP1;
               end else begin
                  state_in = load ? S_EXEC : S_IDLE;
               end
            end
         end
         S_RSP1: begin
            if (rsp_ready) begin
               state_in = load ? S_EXEC : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `MLA_ASSERT_SAME(a_accept_only_on_final, clock, reset, req_ready && (state_ff != S_IDLE), rsp_valid && rsp_ready, "request taken while a result is still pending")
   `MLA_ASSERT_NEXT(a_accept_goes_exec, clock, reset, req_valid && req_ready, state_ff == S_EXEC, "accepted request not executed next")
   `MLA_ASSERT_SAME(a_exec_count_range, clock, reset, state_ff == S_EXEC, stat.exec_cnt != 2'd3, "request decided more than two results")
   `MLA_ASSERT_SAME(a_second_needs_two, clock, reset, state_ff == S_RSP1, stat.res_cnt == 2'd2, "second result shown for a one-result request")

endmodule

`default_nettype wire
